// ===== design/tim_pkg.sv =====
package tim_pkg;

   localparam int MAX_RANK    = 4;
   localparam int EXTENT_BITS = 8;
   localparam int INDEX_BITS  = 32;
   localparam int RANK_BITS   = 3;
   localparam int CSR_IDX_BITS = 3;

   localparam int DIV_BITS_PER_STAGE = 4;
   localparam int DIV_STAGES = INDEX_BITS / DIV_BITS_PER_STAGE;
   localparam int DIV_FIRST  = 1;
   localparam int DIV_LAST   = DIV_FIRST + (MAX_RANK - 1) * DIV_STAGES - 1;
   localparam int SCAT_STG   = DIV_LAST + 1;
   localparam int LAST_STG   = SCAT_STG + MAX_RANK - 1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RANK          = 3'd0,
      CSR_EXTENT_0      = 3'd1,
      CSR_EXTENT_1      = 3'd2,
      CSR_EXTENT_2      = 3'd3,
      CSR_EXTENT_3      = 3'd4,
      CSR_PERM_MAP      = 3'd5,
      CSR_ELEMENT_COUNT = 3'd6
   } csr_index_type;

   typedef logic [EXTENT_BITS-1:0] extent_type;
   typedef logic [INDEX_BITS-1:0]  index_type;

   typedef struct packed {
      logic                          valid;
      logic                          err;
      index_type                     w;
      extent_type                    rem;
      logic [MAX_RANK-1:0][INDEX_BITS-1:0] c;
   } stage_type;

endpackage

// ===== design/transpose_index_mapper.sv =====
// Channel | Direction | Handshake           | Payload
// req     | in        | req_tvalid/tready   | tdata[31:0] transposed_index
// rsp     | out       | rsp_tvalid/tready   | tdata[31:0] source_index, tuser[0] index_error
// csr     | in        | csr_valid/csr_ready | csr_index[2:0], csr_data[31:0]
//
// One request per cycle while the result is not stalled; one input stage, 24
// stages of 4-bit restoring division by an extent (3 dimensions x 8), one
// scatter stage and 3 multiply-add stages of the recomposition.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous) clears valid bits and loads the default configuration.
module transpose_index_mapper (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tim_pkg::INDEX_BITS-1:0] req_tdata,   // [31:0] transposed_index
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tim_pkg::INDEX_BITS-1:0] rsp_tdata,   // [31:0] source_index
   output logic                          rsp_tuser,   // [0] index_error
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tim_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import tim_pkg::*;

   logic [RANK_BITS-1:0]       rank_ff;
   extent_type [MAX_RANK-1:0]  extent_ff;
   logic [2*MAX_RANK-1:0]      perm_map_ff;
   index_type                  element_count_ff;

   logic [RANK_BITS-1:0]       rk;
   stage_type                  stg_ff [0:LAST_STG];
   stage_type                  stg_in [0:LAST_STG];
   logic                       adv;

   function automatic extent_type ext_of(input extent_type e);
      return (e == '0) ? extent_type'(1) : e;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff          <= RANK_BITS'(1);
         extent_ff        <= {MAX_RANK{extent_type'(1)}};
         perm_map_ff      <= 8'd228;
         element_count_ff <= index_type'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RANK:          rank_ff          <= csr_data[RANK_BITS-1:0];
            CSR_EXTENT_0:      extent_ff[0]     <= csr_data[EXTENT_BITS-1:0];
            CSR_EXTENT_1:      extent_ff[1]     <= csr_data[EXTENT_BITS-1:0];
            CSR_EXTENT_2:      extent_ff[2]     <= csr_data[EXTENT_BITS-1:0];
            CSR_EXTENT_3:      extent_ff[3]     <= csr_data[EXTENT_BITS-1:0];
            CSR_PERM_MAP:      perm_map_ff      <= csr_data[7:0];
            CSR_ELEMENT_COUNT: element_count_ff <= csr_data[INDEX_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rank_ff == '0)
         rk = RANK_BITS'(1);
      else if (rank_ff > RANK_BITS'(MAX_RANK))
         rk = RANK_BITS'(MAX_RANK);
      else
         rk = rank_ff;
   end

   assign adv        = !stg_ff[LAST_STG].valid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = stg_ff[LAST_STG].valid;
   assign rsp_tuser  = stg_ff[LAST_STG].err;
   assign rsp_tdata  = stg_ff[LAST_STG].err ? '0 : stg_ff[LAST_STG].w;

   always_comb begin
      stg_in[0]       = '0;
      stg_in[0].valid = req_tvalid;
      stg_in[0].w     = req_tdata;
      stg_in[0].err   = req_tdata >= element_count_ff;
   end

   // inner dimensions first: remainder is the coordinate, quotient goes on
   for (genvar s = DIV_FIRST; s <= DIV_LAST; s++) begin : g_div
      localparam int DIM  = MAX_RANK - 1 - (s - DIV_FIRST) / DIV_STAGES;
      localparam bit LAST = ((s - DIV_FIRST) % DIV_STAGES) == DIV_STAGES - 1;
      always_comb begin
         logic [EXTENT_BITS:0] t;
         extent_type           dv;
         stg_in[s] = stg_ff[s-1];
         dv = ext_of(extent_ff[perm_map_ff[2*DIM +: 2]]);
         t  = '0;
         if (rk > RANK_BITS'(DIM)) begin
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
               t = {stg_in[s].rem, stg_in[s].w[INDEX_BITS-1]};
               stg_in[s].w = {stg_in[s].w[INDEX_BITS-2:0], 1'b0};
               if (t >= {1'b0, dv}) begin
                  t = t - {1'b0, dv};
                  stg_in[s].w[0] = 1'b1;
               end
               stg_in[s].rem = t[EXTENT_BITS-1:0];
            end
         end
         if (LAST) begin
            stg_in[s].c[DIM] = (rk > RANK_BITS'(DIM)) ?
                               INDEX_BITS'(stg_in[s].rem) : '0;
            stg_in[s].rem = '0;
         end
      end
   end

   // scatter: later output dimension wins on a repeated source slot
   always_comb begin
      logic [MAX_RANK-1:0][INDEX_BITS-1:0] sc;
      index_type cd;
      stg_in[SCAT_STG] = stg_ff[SCAT_STG-1];
      sc = '0;
      for (int k = 0; k < MAX_RANK; k++) begin
         for (int d = 0; d < MAX_RANK; d++) begin
            cd = (d == 0) ? stg_ff[SCAT_STG-1].w : stg_ff[SCAT_STG-1].c[d];
            if (rk > RANK_BITS'(d) && perm_map_ff[2*d +: 2] == 2'(k))
               sc[k] = cd;
         end
      end
      stg_in[SCAT_STG].c = sc;
      stg_in[SCAT_STG].w = sc[0];
   end

   for (genvar s = SCAT_STG + 1; s <= LAST_STG; s++) begin : g_mac
      localparam int K = s - SCAT_STG;
      always_comb begin
         stg_in[s] = stg_ff[s-1];
         if (rk > RANK_BITS'(K))
            stg_in[s].w = INDEX_BITS'(stg_ff[s-1].w * ext_of(extent_ff[K]))
                          + stg_ff[s-1].c[K];
      end
   end

   for (genvar s = 0; s <= LAST_STG; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[s].valid <= 1'b0;
         end else if (adv) begin
            stg_ff[s] <= stg_in[s];
         end
      end
   end

endmodule

// ===== sim/transpose_index_mapper_tb.sv =====
module transpose_index_mapper_tb;
   import tim_pkg::*;

   localparam int WATCHDOG_CYCLES = 20000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int RANDOM_REQUESTS = 1300;

   typedef struct {
      logic [31:0] source_index;
      logic        index_error;
   } mapped_addr_type;

   typedef struct {
      logic [31:0] transposed_index;
      logic        known;
      logic [31:0] source_index;
      logic        index_error;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // shadow configuration
   logic [2:0]  cfg_rank;
   logic [7:0]  cfg_extent [4];
   logic [7:0]  cfg_perm;
   logic [31:0] cfg_count;

   mapped_addr_type expected_addrs [$];
   int mismatches = 0;
   int results_seen = 0;
   int error_results = 0;
   int idle_cycles = 0;
   bit no_idle = 1'b0;
   bit timed_out = 1'b0;

   transpose_index_mapper i_dut (.*);

   always #5 clock = ~clock;

   function automatic mapped_addr_type map_index(logic [31:0] idx);
      mapped_addr_type res;
      int unsigned r;
      logic [63:0] tstride [4];
      logic [63:0] sstride [4];
      logic [63:0] coord [4];
      logic [63:0] s, rem, acc, e;
      int unsigned p;
      r = (cfg_rank == 0) ? 1 : (cfg_rank > 4 ? 4 : cfg_rank);
      res.source_index = '0;
      res.index_error = 1'b0;
      if (idx >= cfg_count) begin
         res.index_error = 1'b1;
         return res;
      end
      s = 1;
      for (int k = r - 1; k >= 0; k--) begin
         tstride[k] = s;
         p = cfg_perm[2*k +: 2];
         e = (cfg_extent[p] == 0) ? 1 : cfg_extent[p];
         s = s * e;
      end
      s = 1;
      for (int k = r - 1; k >= 0; k--) begin
         sstride[k] = s;
         e = (cfg_extent[k] == 0) ? 1 : cfg_extent[k];
         s = s * e;
      end
      for (int d = 0; d < 4; d++) coord[d] = 0;
      rem = idx;
      for (int d = 0; d < r; d++) begin
         p = cfg_perm[2*d +: 2];
         coord[p] = rem / tstride[d];
         rem = rem % tstride[d];
      end
      acc = 0;
      for (int d = 0; d < r; d++) acc += coord[d] * sstride[d];
      res.source_index = acc[31:0];
      return res;
   endfunction

   function automatic bit idle_now();
      return !no_idle && ($urandom_range(99) < 28);
   endfunction

   task automatic write_csr(csr_index_type which, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (which)
         CSR_RANK:          cfg_rank = value[2:0];
         CSR_EXTENT_0:      cfg_extent[0] = value[7:0];
         CSR_EXTENT_1:      cfg_extent[1] = value[7:0];
         CSR_EXTENT_2:      cfg_extent[2] = value[7:0];
         CSR_EXTENT_3:      cfg_extent[3] = value[7:0];
         CSR_PERM_MAP:      cfg_perm = value[7:0];
         CSR_ELEMENT_COUNT: cfg_count = value;
         default: ;
      endcase
   endtask

   // unused index 7 must be ignored
   task automatic write_unused_csr(logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= 3'(CSR_ELEMENT_COUNT) + 3'd1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_addrs.size() != 0 && !timed_out) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_request(logic [31:0] idx, bit known, mapped_addr_type want);
      mapped_addr_type pred;
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      pred = map_index(idx);
      if (known && (pred.source_index !== want.source_index ||
                    pred.index_error !== want.index_error)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row %h: expected %h/%b, predictor %h/%b", idx,
                     want.source_index, want.index_error,
                     pred.source_index, pred.index_error);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= idx;
      do @(posedge clock); while (!req_tready);
      expected_addrs.insert(expected_addrs.size(), pred);
   endtask

   task automatic configure(logic [2:0] r, logic [7:0] e0, logic [7:0] e1,
                            logic [7:0] e2, logic [7:0] e3, logic [7:0] perm,
                            bit consistent);
      logic [63:0] prod;
      int unsigned rr;
      rr = (r == 0) ? 1 : (r > 4 ? 4 : r);
      prod = 1;
      if (rr > 0) prod *= (e0 == 0) ? 1 : e0;
      if (rr > 1) prod *= (e1 == 0) ? 1 : e1;
      if (rr > 2) prod *= (e2 == 0) ? 1 : e2;
      if (rr > 3) prod *= (e3 == 0) ? 1 : e3;
      write_csr(CSR_RANK, {29'd0, r});
      write_csr(CSR_EXTENT_0, {24'd0, e0});
      write_csr(CSR_EXTENT_1, {24'd0, e1});
      write_csr(CSR_EXTENT_2, {24'd0, e2});
      write_csr(CSR_EXTENT_3, {24'd0, e3});
      write_csr(CSR_PERM_MAP, {24'd0, perm});
      write_csr(CSR_ELEMENT_COUNT, consistent ? prod[31:0] :
                prod[31:0] + $urandom_range(1, 3 * prod[31:0]));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] valid_perm(int unsigned r);
      int unsigned p [4];
      int unsigned j, t;
      for (int i = 0; i < 4; i++) p[i] = i;
      for (int i = r - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = p[i]; p[i] = p[j]; p[j] = t;
      end
      return {2'(p[3]), 2'(p[2]), 2'(p[1]), 2'(p[0])};
   endfunction

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !idle_now();
   end

   always @(posedge clock) begin
      mapped_addr_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser) error_results++;
         if (expected_addrs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h/%b", rsp_tdata, rsp_tuser);
         end else begin
            want = expected_addrs.pop_front();
            if (rsp_tdata !== want.source_index || rsp_tuser !== want.index_error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected %h/%b, got %h/%b", results_seen,
                           want.source_index, want.index_error, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog expired, %0d results outstanding", expected_addrs.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   directed_row_type reset_rows [4] = '{
      '{32'd0,          1'b1, 32'd0, 1'b0},
      '{32'd1,          1'b1, 32'd0, 1'b1},
      '{32'hFFFF_FFFF,  1'b1, 32'd0, 1'b1},
      '{32'h8000_0000,  1'b1, 32'd0, 1'b1}
   };

   // 2x3x4 tensor, perm 2,0,1 => transposed shape 4x2x3
   directed_row_type perm_rows [8] = '{
      '{32'd0,  1'b1, 32'd0,  1'b0},
      '{32'd1,  1'b1, 32'd4,  1'b0},
      '{32'd3,  1'b1, 32'd12, 1'b0},
      '{32'd6,  1'b1, 32'd1,  1'b0},
      '{32'd23, 1'b1, 32'd23, 1'b0},
      '{32'd11, 1'b0, 32'd0,  1'b0},
      '{32'd24, 1'b1, 32'd0,  1'b1},
      '{32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1}
   };

   initial begin
      mapped_addr_type want;
      int unsigned r, n;
      logic [7:0] e [4];
      logic [31:0] idx;
      cfg_rank = 3'd1;
      for (int i = 0; i < 4; i++) cfg_extent[i] = 8'd1;
      cfg_perm = 8'd228;
      cfg_count = 32'd1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (reset_rows[i]) begin
         want.source_index = reset_rows[i].source_index;
         want.index_error = reset_rows[i].index_error;
         send_request(reset_rows[i].transposed_index, reset_rows[i].known, want);
      end
      wait_drained();

      write_unused_csr(32'hFFFF_FFFF);
      configure(3'd3, 8'd2, 8'd3, 8'd4, 8'd1, {2'd3, 2'd1, 2'd0, 2'd2}, 1'b1);
      foreach (perm_rows[i]) begin
         want.source_index = perm_rows[i].source_index;
         want.index_error = perm_rows[i].index_error;
         send_request(perm_rows[i].transposed_index, perm_rows[i].known, want);
      end
      wait_drained();

      // max extents, full rank, reversed order; zero extent and rank zero / seven
      configure(3'd7, 8'd255, 8'd255, 8'd255, 8'd255, 8'h1B, 1'b1);
      send_request(32'd0, 1'b0, want);
      send_request(32'hFC05_FC00, 1'b0, want);
      send_request(32'hFC05_FC01, 1'b1, '{32'd0, 1'b1});
      send_request(32'h5555_AAAA, 1'b0, want);
      wait_drained();
      configure(3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0);
      for (int i = 0; i < 4; i++) send_request($urandom_range(0, 6), 1'b0, want);
      wait_drained();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 100 == 0) begin
            wait_drained();
            no_idle = (i / 100 == 5);
            r = $urandom_range(1, 4);
            for (int k = 0; k < 4; k++)
               e[k] = ($urandom_range(9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 12));
            n = $urandom_range(9);
            configure((n == 0) ? 3'($urandom_range(0, 7)) : 3'(r), e[0], e[1], e[2], e[3],
                      (n < 2) ? 8'($urandom) : valid_perm(r), n != 3);
         end
         case ($urandom_range(9))
            0: idx = $urandom;
            1: idx = cfg_count - $urandom_range(0, 2);
            default: idx = $urandom_range(0, cfg_count - 1);
         endcase
         send_request(idx, 1'b0, want);
      end
      wait_drained();

      $display("%0d results checked, %0d of them index errors, across %0d configurations",
               results_seen, error_results, RANDOM_REQUESTS / 100 + 4);
      if (mismatches == 0 && expected_addrs.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_addrs.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
